>>> design/cssim_pkg.sv
package cssim_pkg;

  localparam int unsigned MAX_PROCESSES = 64;
  localparam int unsigned FRACTION_BITS = 8;

  localparam int unsigned IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CLK_W  = 39;
  localparam int unsigned SUM_W  = 45;
  localparam int unsigned AVG_W  = 47;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CNTO_W = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // divider operand widths
  localparam int unsigned DVD_W = SUM_W + FRACTION_BITS;
  localparam int unsigned DVS_W = CNT_W + TIME_W;

  localparam logic [MODE_W-1:0] MODE_FCFS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRIO = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SRTF = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_QUANTUM   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_ZEROBURST = 3'd4;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_OVF  = 2'd1;
  localparam logic [1:0] FAULT_ZB   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] prio;
  } entry_t;

endpackage

>>> design/cssim_in_if.sv
interface cssim_in_if;
  import cssim_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] burst_len;
  logic [TIME_W-1:0] priority_level;
  logic [TIME_W-1:0] arrive_at;

  modport source (output valid, kind, burst_len, priority_level, arrive_at, input ready);
  modport sink   (input valid, kind, burst_len, priority_level, arrive_at, output ready);
endinterface

>>> design/cssim_out_if.sv
interface cssim_out_if;
  import cssim_pkg::*;
  logic              valid;
  logic              ready;
  logic [ERR_W-1:0]  error_code;
  logic [AVG_W-1:0]  average_wait;
  logic [AVG_W-1:0]  average_turnaround;
  logic [CLK_W-1:0]  run_span;
  logic [CNTO_W-1:0] process_count;

  modport source (output valid, error_code, average_wait, average_turnaround,
                  run_span, process_count, input ready);
  modport sink   (input valid, error_code, average_wait, average_turnaround,
                  run_span, process_count, output ready);
endinterface

>>> design/cssim_ram.sv
module cssim_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/cssim_div.sv
module cssim_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cssim_pkg::DVD_W-1:0] dividend_i,
  input  logic [cssim_pkg::DVS_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [cssim_pkg::DVD_W-1:0] quotient_o
);
  import cssim_pkg::*;

  localparam int unsigned ITER_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = ~diff[DVS_W+1];
    busy_d = busy_q;
    iter_d = iter_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = ITER_W'(DVD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_d  = {quo_q[DVD_W-2:0], ge};
      iter_d = iter_q - ITER_W'(1);
      busy_d = (iter_q != ITER_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;
endmodule

>>> design/cpu_schedule_simulator_core.sv
// CPU schedule simulator.
// in_i carries requests: kind 0 loads one process (burst, priority, arrival)
// into the table, kind 1 runs the policy register's policy over the loaded
// set and yields one result request on out_o. Loads give no result.
// A load keeps the core idle; it takes a new request in every idle cycle.
// A run walks the table over simulated time, each entry visit a read state
// (S_RD) then an evaluate state (S_EX): each decision is one scan of all N
// entries, then a short action. Round robin adds a pass over the table per
// round and uses the shared divider to skip rounds in which nothing happens;
// the two averages take two more divisions. The run time scales with N times
// the number of events. Reset clears the table count, faults, finished flags
// and the registers (policy fcfs, quantum 1); table memory keeps no reset
// value and needs no clearing pass. When out_o is stalled the finished result
// holds in the output register; the core keeps taking loads, and a following
// run stops before its emit until the register frees up. Configuration
// writes (cfg_we_i) take effect at once; the user must make them only while
// idle, as the core itself does not enforce this.
module cpu_schedule_simulator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cssim_in_if.sink                            in_i,
  cssim_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [cssim_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cssim_pkg::TIME_W-1:0]        cfg_wdata_i
);
  import cssim_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE      = 20'h00001,
    S_RD        = 20'h00002,
    S_EX        = 20'h00004,
    S_DECIDE    = 20'h00008,
    S_SRTF      = 20'h00010,
    S_MARK      = 20'h00020,
    S_SPAN      = 20'h00040,
    S_DIVK_GO   = 20'h00080,
    S_DIVK_WAIT = 20'h00100,
    S_DIVL_GO   = 20'h00200,
    S_DIVL_WAIT = 20'h00400,
    S_KQ        = 20'h00800,
    S_KSPAN     = 20'h01000,
    S_SKIP_ADV  = 20'h02000,
    S_PASS_WR   = 20'h04000,
    S_DIVW_GO   = 20'h08000,
    S_DIVW_WAIT = 20'h10000,
    S_DIVT_GO   = 20'h20000,
    S_DIVT_WAIT = 20'h40000,
    S_EMIT      = 20'h80000
  } state_e;

  typedef enum logic [1:0] {
    WALK_SCAN = 2'd0,
    WALK_SKIP = 2'd1,
    WALK_PASS = 2'd2
  } walk_e;

  function automatic logic [TIME_W-1:0] key_of(input logic [MODE_W-1:0] mode,
                                               input entry_t ent,
                                               input logic [TIME_W-1:0] rem);
    logic [TIME_W-1:0] k;
    begin
      k = ent.arr;
      if (mode == MODE_SJF) k = ent.burst;
      else if (mode == MODE_PRIO) k = ent.prio;
      else if (mode == MODE_SRTF) k = rem;
      return k;
    end
  endfunction

  state_e st_q, st_d;
  walk_e  walk_q, walk_d;

  logic [MODE_W-1:0]        policy_q, policy_d;
  logic [TIME_W-1:0]        quantum_q, quantum_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [1:0]               fault_q, fault_d;
  logic [MAX_PROCESSES-1:0] fin_q, fin_d;
  logic [CLK_W-1:0]         clk_q, clk_d;
  logic [SUM_W-1:0]         wt_q, wt_d, tt_q, tt_d;
  logic [CNT_W-1:0]         done_q, done_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic [ERR_W-1:0]         err_q, err_d;

  // scan results
  logic              best_v_q, best_v_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_key_q, best_key_d;
  logic [TIME_W-1:0] best_arr_q, best_arr_d;
  logic [TIME_W-1:0] best_burst_q, best_burst_d;
  logic [TIME_W-1:0] best_rem_q, best_rem_d;
  logic              nxt_v_q, nxt_v_d;
  logic [TIME_W-1:0] nxt_q, nxt_d;
  logic [CNT_W-1:0]  m_q, m_d;
  logic [TIME_W-1:0] rmin_q, rmin_d;

  logic [CLK_W-1:0]  len_q, len_d;
  logic [DVS_W-1:0]  span_q, span_d;
  logic [TIME_W-1:0] k_q, k_d;
  logic [TIME_W-1:0] kq_q, kq_d;
  logic [CLK_W-1:0]  kspan_q, kspan_d;
  logic [TIME_W-1:0] slice_q, slice_d;
  logic [IDX_W-1:0]  mark_idx_q, mark_idx_d;
  logic [TIME_W-1:0] mark_arr_q, mark_arr_d;
  logic [TIME_W-1:0] mark_burst_q, mark_burst_d;
  logic              mark_pass_q, mark_pass_d;
  logic [AVG_W-1:0]  avgw_q, avgw_d;

  logic              ov_q, ov_d;
  logic [ERR_W-1:0]  oerr_q, oerr_d;
  logic [AVG_W-1:0]  ow_q, ow_d, ot_q, ot_d;
  logic [CLK_W-1:0]  oclk_q, oclk_d;
  logic [CNTO_W-1:0] ocnt_q, ocnt_d;

  // memories
  logic              we_a;
  entry_t            wdata_a, ent;
  logic              we_b;
  logic [IDX_W-1:0]  waddr_b;
  logic [TIME_W-1:0] wdata_b, rem;
  logic [IDX_W-1:0]  raddr;

  // divider
  logic              div_start, div_busy;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [DVS_W-1:0]  div_dvs;

  logic [IDX_W-1:0]  cur;
  logic              last, rdy, later, in_acc;
  logic [CLK_W-1:0]  t_ext, nxt_gap, lim_num;
  logic [TIME_W-1:0] key, new_rem;
  logic [2*TIME_W-1:0] kq_full;

  cssim_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_PROCESSES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wdata_a),
    .raddr_i (raddr),
    .rdata_o (ent)
  );

  cssim_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCESSES)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (wdata_b),
    .raddr_i (raddr),
    .rdata_o (rem)
  );

  cssim_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign in_i.ready = (st_q == S_IDLE);
  assign in_acc     = in_i.valid && (st_q == S_IDLE);
  assign raddr      = idx_q[IDX_W-1:0];
  assign cur        = idx_q[IDX_W-1:0];
  assign last       = ((idx_q + CNT_W'(1)) == count_q);
  assign rdy        = !fin_q[cur] && (CLK_W'(ent.arr) <= clk_q);
  assign later      = !fin_q[cur] && (CLK_W'(ent.arr) > clk_q);
  assign key        = key_of(policy_q, ent, rem);
  assign nxt_gap    = CLK_W'(nxt_q) - clk_q;
  assign lim_num    = CLK_W'(nxt_q) - CLK_W'(1) - clk_q;
  assign t_ext      = clk_q - CLK_W'(mark_arr_q);
  assign kq_full    = (2*TIME_W)'(k_q) * (2*TIME_W)'(quantum_q);

  assign wdata_a.arr   = in_i.arrive_at;
  assign wdata_a.burst = in_i.burst_len;
  assign wdata_a.prio  = in_i.priority_level;
  assign we_a = in_acc && (in_i.kind == KIND_LOAD) &&
                (count_q < CNT_W'(MAX_PROCESSES)) && (in_i.burst_len != '0);

  // remaining-time write port: load, round skip, round-robin slice, srtf run
  always_comb begin
    we_b    = 1'b0;
    waddr_b = cur;
    wdata_b = rem;
    new_rem = rem - slice_q;
    if (st_q == S_IDLE) begin
      we_b    = we_a;
      waddr_b = count_q[IDX_W-1:0];
      wdata_b = in_i.burst_len;
    end else if (st_q == S_EX && walk_q == WALK_SKIP) begin
      we_b    = rdy;
      wdata_b = rem - kq_q;
    end else if (st_q == S_PASS_WR) begin
      we_b    = 1'b1;
      wdata_b = new_rem;
    end else if (st_q == S_SRTF) begin
      we_b    = 1'b1;
      waddr_b = best_idx_q;
      wdata_b = best_rem_q - len_q[TIME_W-1:0];
    end
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {wt_q, {FRACTION_BITS{1'b0}}};
    div_dvs   = DVS_W'(count_q);
    unique case (st_q)
      S_DIVK_GO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(rmin_q - TIME_W'(1));
        div_dvs   = DVS_W'(quantum_q);
      end
      S_DIVL_GO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(lim_num);
        div_dvs   = span_q;
      end
      S_DIVW_GO: begin
        div_start = 1'b1;
      end
      S_DIVT_GO: begin
        div_start = 1'b1;
        div_dvd   = {tt_q, {FRACTION_BITS{1'b0}}};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_d = st_q; walk_d = walk_q;
    policy_d = policy_q; quantum_d = quantum_q;
    count_d = count_q; fault_d = fault_q; fin_d = fin_q;
    clk_d = clk_q; wt_d = wt_q; tt_d = tt_q; done_d = done_q;
    idx_d = idx_q; err_d = err_q;
    best_v_d = best_v_q; best_idx_d = best_idx_q; best_key_d = best_key_q;
    best_arr_d = best_arr_q; best_burst_d = best_burst_q; best_rem_d = best_rem_q;
    nxt_v_d = nxt_v_q; nxt_d = nxt_q; m_d = m_q; rmin_d = rmin_q;
    len_d = len_q; span_d = span_q; k_d = k_q; kq_d = kq_q; kspan_d = kspan_q;
    slice_d = slice_q; mark_idx_d = mark_idx_q; mark_arr_d = mark_arr_q;
    mark_burst_d = mark_burst_q; mark_pass_d = mark_pass_q; avgw_d = avgw_q;
    ov_d = ov_q; oerr_d = oerr_q; ow_d = ow_q; ot_d = ot_q;
    oclk_d = oclk_q; ocnt_d = ocnt_q;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    if (cfg_we_i) begin
      if (cfg_idx_i == REG_POLICY) policy_d = cfg_wdata_i[MODE_W-1:0];
      else quantum_d = cfg_wdata_i;
    end

    unique case (st_q)
      S_IDLE: begin
        if (in_acc && in_i.kind == KIND_LOAD) begin
          if (count_q >= CNT_W'(MAX_PROCESSES)) begin
            if (fault_q == FAULT_NONE) fault_d = FAULT_OVF;
          end else if (in_i.burst_len == '0) begin
            if (fault_q == FAULT_NONE) fault_d = FAULT_ZB;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end else if (in_acc) begin
          fin_d  = '0;
          clk_d  = '0;
          wt_d   = '0;
          tt_d   = '0;
          done_d = '0;
          if (fault_q == FAULT_OVF) err_d = ERR_OVERFLOW;
          else if (fault_q == FAULT_ZB) err_d = ERR_ZEROBURST;
          else if (count_q == '0) err_d = ERR_EMPTY;
          else if (policy_q == MODE_RR && quantum_q == '0) err_d = ERR_QUANTUM;
          else err_d = ERR_OK;
          if (fault_q != FAULT_NONE || count_q == '0 ||
              (policy_q == MODE_RR && quantum_q == '0)) begin
            st_d = S_EMIT;
          end else begin
            // start the first scan
            walk_d = WALK_SCAN; idx_d = '0; best_v_d = 1'b0; nxt_v_d = 1'b0;
            m_d = '0; st_d = S_RD;
          end
        end
      end
      S_RD: begin
        st_d = S_EX;
      end
      S_EX: begin
        unique case (walk_q)
          WALK_SCAN: begin
            if (rdy) begin
              m_d = m_q + CNT_W'(1);
              if (m_q == '0 || rem < rmin_q) rmin_d = rem;
              if (!best_v_q || key < best_key_q) begin
                best_v_d = 1'b1; best_idx_d = cur; best_key_d = key;
                best_arr_d = ent.arr; best_burst_d = ent.burst; best_rem_d = rem;
              end
            end
            if (later && (!nxt_v_q || ent.arr < nxt_q)) begin
              nxt_v_d = 1'b1; nxt_d = ent.arr;
            end
            if (last) st_d = S_DECIDE;
            else begin idx_d = idx_q + CNT_W'(1); st_d = S_RD; end
          end
          WALK_SKIP: begin
            if (last) st_d = S_SKIP_ADV;
            else begin idx_d = idx_q + CNT_W'(1); st_d = S_RD; end
          end
          WALK_PASS: begin
            if (rdy) begin
              slice_d = (rem > quantum_q) ? quantum_q : rem;
              st_d = S_PASS_WR;
            end else if (last) begin
              walk_d = WALK_SCAN; idx_d = '0; best_v_d = 1'b0; nxt_v_d = 1'b0;
              m_d = '0; st_d = S_RD;
            end else begin
              idx_d = idx_q + CNT_W'(1); st_d = S_RD;
            end
          end
          default: st_d = S_IDLE;
        endcase
      end
      S_DECIDE: begin
        idx_d = '0; best_v_d = 1'b0; nxt_v_d = 1'b0; m_d = '0;
        walk_d = WALK_SCAN;
        st_d = S_RD;
        if (done_q == count_q) begin
          st_d = S_DIVW_GO;
        end else if (policy_q == MODE_RR) begin
          if (m_q == '0) clk_d = CLK_W'(nxt_q);
          else begin
            st_d = S_SPAN; best_v_d = best_v_q; nxt_v_d = nxt_v_q; m_d = m_q;
          end
        end else if (!best_v_q) begin
          // idle processor: jump to the next arrival and scan again
          clk_d = CLK_W'(nxt_q);
        end else if (policy_q == MODE_SRTF) begin
          len_d = (nxt_v_q && nxt_gap < CLK_W'(best_rem_q)) ? nxt_gap
                                                              : CLK_W'(best_rem_q);
          best_v_d = 1'b1;
          st_d = S_SRTF;
        end else begin
          clk_d = clk_q + CLK_W'(best_burst_q);
          mark_idx_d = best_idx_q; mark_arr_d = best_arr_q;
          mark_burst_d = best_burst_q; mark_pass_d = 1'b0;
          st_d = S_MARK;
        end
      end
      S_SRTF: begin
        clk_d = clk_q + len_q;
        if (best_rem_q == len_q[TIME_W-1:0]) begin
          mark_idx_d = best_idx_q; mark_arr_d = best_arr_q;
          mark_burst_d = best_burst_q; mark_pass_d = 1'b0;
          st_d = S_MARK;
        end else begin
          walk_d = WALK_SCAN; idx_d = '0; best_v_d = 1'b0; nxt_v_d = 1'b0;
          m_d = '0; st_d = S_RD;
        end
      end
      S_MARK: begin
        fin_d[mark_idx_q] = 1'b1;
        tt_d   = tt_q + SUM_W'(t_ext);
        wt_d   = wt_q + SUM_W'(t_ext - CLK_W'(mark_burst_q));
        done_d = done_q + CNT_W'(1);
        if (mark_pass_q && !last) begin
          idx_d = idx_q + CNT_W'(1); st_d = S_RD;
        end else begin
          walk_d = WALK_SCAN; idx_d = '0; best_v_d = 1'b0; nxt_v_d = 1'b0;
          m_d = '0; st_d = S_RD;
        end
      end
      S_SPAN: begin
        span_d = DVS_W'(quantum_q) * DVS_W'(m_q);
        st_d = S_DIVK_GO;
      end
      S_DIVK_GO: st_d = S_DIVK_WAIT;
      S_DIVK_WAIT: begin
        if (!div_busy) begin
          k_d = div_quo[TIME_W-1:0];
          st_d = nxt_v_q ? S_DIVL_GO : S_KQ;
        end
      end
      S_DIVL_GO: st_d = S_DIVL_WAIT;
      S_DIVL_WAIT: begin
        if (!div_busy) begin
          if (div_quo < DVD_W'(k_q)) k_d = div_quo[TIME_W-1:0];
          st_d = S_KQ;
        end
      end
      S_KQ: begin
        kq_d = kq_full[TIME_W-1:0];
        st_d = S_KSPAN;
      end
      S_KSPAN: begin
        kspan_d = CLK_W'(kq_q) * CLK_W'(m_q);
        idx_d = '0;
        st_d = S_RD;
        walk_d = (k_q == '0) ? WALK_PASS : WALK_SKIP;
      end
      S_SKIP_ADV: begin
        clk_d = clk_q + kspan_q;
        walk_d = WALK_PASS; idx_d = '0; st_d = S_RD;
      end
      S_PASS_WR: begin
        clk_d = clk_q + CLK_W'(slice_q);
        if (new_rem == '0) begin
          mark_idx_d = cur; mark_arr_d = ent.arr; mark_burst_d = ent.burst;
          mark_pass_d = 1'b1;
          st_d = S_MARK;
        end else if (last) begin
          walk_d = WALK_SCAN; idx_d = '0; best_v_d = 1'b0; nxt_v_d = 1'b0;
          m_d = '0; st_d = S_RD;
        end else begin
          idx_d = idx_q + CNT_W'(1); st_d = S_RD;
        end
      end
      S_DIVW_GO: st_d = S_DIVW_WAIT;
      S_DIVW_WAIT: begin
        if (!div_busy) begin
          avgw_d = div_quo[AVG_W-1:0];
          st_d = S_DIVT_GO;
        end
      end
      S_DIVT_GO: st_d = S_DIVT_WAIT;
      S_DIVT_WAIT: begin
        if (!div_busy) st_d = S_EMIT;
      end
      S_EMIT: begin
        // hold here until the output register is free
        if (!ov_q || out_o.ready) begin
          ov_d   = 1'b1;
          oerr_d = err_q;
          ow_d   = (err_q == ERR_OK) ? avgw_q : '0;
          ot_d   = (err_q == ERR_OK) ? div_quo[AVG_W-1:0] : '0;
          oclk_d = (err_q == ERR_OK) ? clk_q : '0;
          ocnt_d = CNTO_W'(count_q);
          count_d = '0;
          fault_d = FAULT_NONE;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      walk_q    <= WALK_SCAN;
      policy_q  <= MODE_FCFS;
      quantum_q <= TIME_W'(1);
      count_q   <= '0;
      fault_q   <= FAULT_NONE;
      fin_q     <= '0;
      done_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      st_q      <= st_d;
      walk_q    <= walk_d;
      policy_q  <= policy_d;
      quantum_q <= quantum_d;
      count_q   <= count_d;
      fault_q   <= fault_d;
      fin_q     <= fin_d;
      done_q    <= done_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clk_q <= clk_d; wt_q <= wt_d; tt_q <= tt_d; idx_q <= idx_d; err_q <= err_d;
    best_v_q <= best_v_d; best_idx_q <= best_idx_d; best_key_q <= best_key_d;
    best_arr_q <= best_arr_d; best_burst_q <= best_burst_d; best_rem_q <= best_rem_d;
    nxt_v_q <= nxt_v_d; nxt_q <= nxt_d; m_q <= m_d; rmin_q <= rmin_d;
    len_q <= len_d; span_q <= span_d; k_q <= k_d; kq_q <= kq_d; kspan_q <= kspan_d;
    slice_q <= slice_d; mark_idx_q <= mark_idx_d; mark_arr_q <= mark_arr_d;
    mark_burst_q <= mark_burst_d; mark_pass_q <= mark_pass_d; avgw_q <= avgw_d;
    oerr_q <= oerr_d; ow_q <= ow_d; ot_q <= ot_d; oclk_q <= oclk_d; ocnt_q <= ocnt_d;
  end

  assign out_o.valid              = ov_q;
  assign out_o.error_code         = oerr_q;
  assign out_o.average_wait       = ow_q;
  assign out_o.average_turnaround = ot_q;
  assign out_o.run_span           = oclk_q;
  assign out_o.process_count      = ocnt_q;
endmodule

>>> dv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cssim_pkg::*;

  // One expected result request, field by field at the port widths.
  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic [AVG_W-1:0]  avg_wait;
    logic [AVG_W-1:0]  avg_tat;
    logic [CLK_W-1:0]  run_time;
    logic [CNTO_W-1:0] count;
  } sched_result_t;

  // Directed stimulus: a request or a register write, with an optional typed-in result.
  typedef enum logic [1:0] {ROW_LOAD, ROW_RUN, ROW_POLICY, ROW_QUANTUM} row_op_e;

  typedef struct {
    row_op_e       op;
    logic [31:0]   burst;
    logic [31:0]   prio;
    logic [31:0]   arr;
    bit            typed;
    sched_result_t res;
  } dir_row_t;

  localparam int unsigned SETS_ITEMS_PER_PHASE = 615;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [TIME_W-1:0] cfg_wdata_i = '0;

  cssim_in_if  in_if ();
  cssim_out_if out_if ();

  cpu_schedule_simulator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Scheduler predictor: its own copy of the process table and registers.
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] pol_reg = MODE_FCFS;
  logic [31:0]       quantum_reg = 32'd1;
  logic [31:0]       tbl_arr [MAX_PROCESSES];
  logic [31:0]       tbl_burst [MAX_PROCESSES];
  logic [31:0]       tbl_left [MAX_PROCESSES];
  logic [31:0]       tbl_prio [MAX_PROCESSES];
  bit                tbl_done [MAX_PROCESSES];
  int unsigned       tbl_n = 0;
  logic [1:0]        fault = FAULT_NONE;
  longint unsigned   now_t, wait_sum, tat_sum;
  int unsigned       done_n;

  function automatic void retire(int i);
    longint unsigned t;
    t = now_t - longint'(tbl_arr[i]);
    tbl_done[i] = 1'b1;
    tat_sum += t;
    wait_sum += t - longint'(tbl_burst[i]);
    done_n++;
  endfunction

  function automatic longint unsigned order_key(int i, logic [MODE_W-1:0] m);
    if (m == MODE_SJF) return tbl_burst[i];
    if (m == MODE_PRIO) return tbl_prio[i];
    if (m == MODE_SRTF) return tbl_left[i];
    return tbl_arr[i];
  endfunction

  // Lowest key among arrived, unfinished processes; ties keep load order.
  function automatic int pick_ready(logic [MODE_W-1:0] m);
    int best;
    best = -1;
    for (int i = 0; i < tbl_n; i++) begin
      if (tbl_done[i] || longint'(tbl_arr[i]) > now_t) continue;
      if (best < 0 || order_key(i, m) < order_key(best, m)) best = i;
    end
    return best;
  endfunction

  // Advance the clock to the earliest pending arrival when nothing is ready.
  function automatic void jump_idle();
    longint unsigned e;
    bit have;
    have = 1'b0;
    e = 0;
    for (int i = 0; i < tbl_n; i++) begin
      if (tbl_done[i]) continue;
      if (!have || tbl_arr[i] < e) begin
        e = tbl_arr[i];
        have = 1'b1;
      end
    end
    if (have && e > now_t) now_t = e;
  endfunction

  function automatic bit next_arrival(output longint unsigned at);
    bit have;
    have = 1'b0;
    at = 0;
    for (int i = 0; i < tbl_n; i++) begin
      if (tbl_done[i] || longint'(tbl_arr[i]) <= now_t) continue;
      if (!have || tbl_arr[i] < at) begin
        at = tbl_arr[i];
        have = 1'b1;
      end
    end
    return have;
  endfunction

  function automatic void run_to_completion(logic [MODE_W-1:0] m);
    int p;
    while (done_n < tbl_n) begin
      p = pick_ready(m);
      if (p < 0) begin
        jump_idle();
        p = pick_ready(m);
        if (p < 0) return;
      end
      now_t += tbl_left[p];
      tbl_left[p] = 0;
      retire(p);
    end
  endfunction

  function automatic void run_shortest_left();
    longint unsigned nxt, len;
    int p;
    while (done_n < tbl_n) begin
      p = pick_ready(MODE_SRTF);
      if (p < 0) begin
        jump_idle();
        continue;
      end
      len = tbl_left[p];
      if (next_arrival(nxt) && nxt - now_t < len) len = nxt - now_t;
      now_t += len;
      tbl_left[p] -= 32'(len);
      if (tbl_left[p] == 0) retire(p);
    end
  endfunction

  function automatic void run_round_robin();
    longint unsigned q, rmin, amin, k, span, lim, slice;
    int unsigned m;
    q = quantum_reg;
    while (done_n < tbl_n) begin
      m = 0;
      rmin = 0;
      for (int i = 0; i < tbl_n; i++) begin
        if (tbl_done[i] || longint'(tbl_arr[i]) > now_t) continue;
        if (m == 0 || tbl_left[i] < rmin) rmin = tbl_left[i];
        m++;
      end
      if (m == 0) begin
        jump_idle();
        continue;
      end
      // Skip whole passes in which nobody finishes and nobody arrives.
      span = longint'(m) * q;
      k = (rmin - 1) / q;
      if (next_arrival(amin)) begin
        lim = (amin - 1 - now_t) / span;
        if (lim < k) k = lim;
      end
      if (k > 0) begin
        for (int i = 0; i < tbl_n; i++) begin
          if (tbl_done[i] || longint'(tbl_arr[i]) > now_t) continue;
          tbl_left[i] -= 32'(k * q);
        end
        now_t += k * span;
      end
      for (int i = 0; i < tbl_n; i++) begin
        if (tbl_done[i] || longint'(tbl_arr[i]) > now_t) continue;
        slice = tbl_left[i];
        if (slice > q) slice = q;
        now_t += slice;
        tbl_left[i] -= 32'(slice);
        if (tbl_left[i] == 0) retire(i);
      end
    end
  endfunction

  // Apply one request to the predictor; a run yields one result.
  function automatic bit predict_request(logic kind, logic [31:0] b, logic [31:0] p,
                                         logic [31:0] a, output sched_result_t r);
    longint unsigned n;
    r = '0;
    if (kind == KIND_LOAD) begin
      if (tbl_n >= MAX_PROCESSES) begin
        if (fault == FAULT_NONE) fault = FAULT_OVF;
      end else if (b == 0) begin
        if (fault == FAULT_NONE) fault = FAULT_ZB;
      end else begin
        tbl_arr[tbl_n] = a;
        tbl_burst[tbl_n] = b;
        tbl_left[tbl_n] = b;
        tbl_prio[tbl_n] = p;
        tbl_done[tbl_n] = 1'b0;
        tbl_n++;
      end
      return 1'b0;
    end
    n = tbl_n;
    now_t = 0;
    wait_sum = 0;
    tat_sum = 0;
    done_n = 0;
    for (int i = 0; i < tbl_n; i++) begin
      tbl_done[i] = 1'b0;
      tbl_left[i] = tbl_burst[i];
    end
    if (fault == FAULT_OVF) r.err = ERR_OVERFLOW;
    else if (fault == FAULT_ZB) r.err = ERR_ZEROBURST;
    else if (n == 0) r.err = ERR_EMPTY;
    else if (pol_reg == MODE_RR && quantum_reg == 0) r.err = ERR_QUANTUM;
    else r.err = ERR_OK;
    if (r.err == ERR_OK) begin
      if (pol_reg == MODE_SJF || pol_reg == MODE_PRIO) run_to_completion(pol_reg);
      else if (pol_reg == MODE_RR) run_round_robin();
      else if (pol_reg == MODE_SRTF) run_shortest_left();
      else run_to_completion(MODE_FCFS);
      r.avg_wait = AVG_W'((wait_sum << FRACTION_BITS) / n);
      r.avg_tat = AVG_W'((tat_sum << FRACTION_BITS) / n);
      r.run_time = CLK_W'(now_t);
    end
    r.count = CNTO_W'(n);
    // Batch end: empty the set and clear the sticky fault.
    tbl_n = 0;
    fault = FAULT_NONE;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  sched_result_t pending_results[$];
  int unsigned fail_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned rx_idle_pct = 0;
  longint unsigned cycle_cnt = 0;

  // Drop ready at random so that finished results meet a stalled receiver.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result request: err=%0d count=%0d", out_if.error_code,
               out_if.process_count);
        fail_cnt++;
      end else begin
        sched_result_t e;
        e = pending_results.pop_front();
        if (out_if.error_code !== e.err) begin
          $error("error_code: expected %0d, got %0d", e.err, out_if.error_code);
          fail_cnt++;
        end
        if (out_if.average_wait !== e.avg_wait) begin
          $error("average_wait: expected %0h, got %0h", e.avg_wait, out_if.average_wait);
          fail_cnt++;
        end
        if (out_if.average_turnaround !== e.avg_tat) begin
          $error("average_turnaround: expected %0h, got %0h", e.avg_tat,
                 out_if.average_turnaround);
          fail_cnt++;
        end
        if (out_if.run_span !== e.run_time) begin
          $error("run_span: expected %0h, got %0h", e.run_time, out_if.run_span);
          fail_cnt++;
        end
        if (out_if.process_count !== e.count) begin
          $error("process_count: expected %0d, got %0d", e.count, out_if.process_count);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run if the core hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("[cpu_schedule_simulator_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  int unsigned tx_idle_pct = 0;
  int unsigned loads_sent = 0;
  int unsigned runs_sent = 0;
  int unsigned runs_per_mode [8];

  // Send one request; hold valid until the core takes it. With a typed-in
  // result, queue that one instead of the predicted one.
  task automatic send_request(logic kind, logic [31:0] b, logic [31:0] p, logic [31:0] a,
                              bit typed = 1'b0, sched_result_t typed_res = '0);
    sched_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.burst_len <= b;
    in_if.priority_level <= p;
    in_if.arrive_at <= a;
    do @(posedge clk_i); while (!in_if.ready);
    if (kind == KIND_RUN) begin
      runs_sent++;
      runs_per_mode[pol_reg]++;
    end else begin
      loads_sent++;
    end
    if (predict_request(kind, b, p, a, r)) begin
      pending_results = {pending_results, (typed ? typed_res : r)};
    end
  endtask

  // Drain all results, let the core settle, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_POLICY) pol_reg = val[MODE_W-1:0];
    else quantum_reg = val;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[$];

  function automatic void add_row(row_op_e op, logic [31:0] b = 0, logic [31:0] p = 0,
                                  logic [31:0] a = 0, bit typed = 0,
                                  sched_result_t res = '0);
    dir_row_t row;
    row.op = op;
    row.burst = b;
    row.prio = p;
    row.arr = a;
    row.typed = typed;
    row.res = res;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void build_directed();
    // empty set right after reset
    add_row(ROW_RUN, 0, 0, 0, 1, '{ERR_EMPTY, '0, '0, '0, 7'd0});
    // single process, default fcfs
    add_row(ROW_LOAD, 5, 0, 0);
    add_row(ROW_RUN, 0, 0, 0, 1, '{ERR_OK, '0, 47'd1280, 39'd5, 7'd1});
    // zero burst is dropped and flagged; the later entry still counts
    add_row(ROW_LOAD, 0, 1, 1);
    add_row(ROW_LOAD, 3, 0, 0);
    add_row(ROW_RUN, 0, 0, 0, 1, '{ERR_ZEROBURST, '0, '0, '0, 7'd1});
    // all fields at their maximum
    add_row(ROW_LOAD, '1, '1, '1);
    add_row(ROW_RUN, 0, 0, 0, 1,
            '{ERR_OK, '0, 47'h0FF_FFFF_FF00, 39'h1_FFFF_FFFE, 7'd1});
    // zero quantum in round robin
    add_row(ROW_QUANTUM, 0);
    add_row(ROW_POLICY, MODE_RR);
    add_row(ROW_LOAD, 4, 0, 0);
    add_row(ROW_RUN, 0, 0, 0, 1, '{ERR_QUANTUM, '0, '0, '0, 7'd1});
    // a small mix under every policy code, defined or not
    add_row(ROW_QUANTUM, 3);
    for (int m = 0; m < 8; m++) begin
      add_row(ROW_POLICY, m);
      add_row(ROW_LOAD, 7, 2, 0);
      add_row(ROW_LOAD, 2, 1, 1);
      add_row(ROW_LOAD, 5, 0, 3);
      add_row(ROW_LOAD, 1, 2, 20);
      add_row(ROW_RUN);
    end
    add_row(ROW_QUANTUM, '1);
    add_row(ROW_POLICY, MODE_RR);
    add_row(ROW_LOAD, '1, 0, 0);
    add_row(ROW_LOAD, 9, 0, 0);
    add_row(ROW_RUN);
  endfunction

  // ---------------------------------------------------------------------------
  // Random batches
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_burst();
    int unsigned c;
    c = $urandom_range(99);
    if (c < 3) return 0;
    if (c < 13) return $urandom;
    return $urandom_range(20, 1);
  endfunction

  // Load one batch and run it. Most are small; a few fill or overflow the table.
  task automatic send_batch(output int unsigned used);
    int unsigned n;
    int unsigned c;
    c = $urandom_range(99);
    if (c < 3) n = $urandom_range(MAX_PROCESSES + 4, MAX_PROCESSES - 2);
    else if (c < 8) n = 0;
    else n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) begin
      send_request(KIND_LOAD, rand_burst(),
                   ($urandom_range(9) == 0) ? $urandom : $urandom_range(3),
                   ($urandom_range(9) == 0) ? $urandom : $urandom_range(30));
    end
    send_request(KIND_RUN, $urandom, $urandom, $urandom);
    used = n + 1;
  endtask

  task automatic random_config();
    int unsigned c;
    write_reg(REG_POLICY, ($urandom_range(9) == 0) ? $urandom : $urandom_range(4));
    c = $urandom_range(99);
    if (c < 5) write_reg(REG_QUANTUM, 0);
    else if (c < 10) write_reg(REG_QUANTUM, '1);
    else if (c < 20) write_reg(REG_QUANTUM, $urandom);
    else write_reg(REG_QUANTUM, $urandom_range(6, 1));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned used;
    int unsigned phase_items;
    int unsigned tx_pct [3];
    int unsigned rx_pct [3];

    tx_pct = '{10, 67, 0};
    rx_pct = '{67, 10, 0};
    in_if.valid = 1'b0;
    in_if.kind = KIND_LOAD;
    in_if.burst_len = '0;
    in_if.priority_level = '0;
    in_if.arrive_at = '0;

    foreach (runs_per_mode[m]) runs_per_mode[m] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed();
    tx_idle_pct = 10;
    rx_idle_pct = 67;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_LOAD: begin
          send_request(KIND_LOAD, dir_rows[i].burst, dir_rows[i].prio, dir_rows[i].arr);
        end
        ROW_RUN: begin
          send_request(KIND_RUN, 0, 0, 0, dir_rows[i].typed, dir_rows[i].res);
        end
        ROW_POLICY: begin
          write_reg(REG_POLICY, dir_rows[i].burst);
        end
        default: begin
          write_reg(REG_QUANTUM, dir_rows[i].burst);
        end
      endcase
    end

    // Three idling profiles; reconfigure between some batches only, so loads
    // keep flowing while a finished result waits on a stalled receiver.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      phase_items = 0;
      random_config();
      while (phase_items < SETS_ITEMS_PER_PHASE) begin
        if ($urandom_range(2) == 0) random_config();
        send_batch(used);
        phase_items += used;
      end
    end

    // Hold off, drain, then let the core settle.
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d loads and %0d runs, %0d results checked", loads_sent,
             runs_sent, results_seen);
    $display("runs per policy code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             runs_per_mode[0], runs_per_mode[1], runs_per_mode[2], runs_per_mode[3],
             runs_per_mode[4], runs_per_mode[5], runs_per_mode[6], runs_per_mode[7]);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("[cpu_schedule_simulator_core] OK");
    end else begin
      $display("[cpu_schedule_simulator_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
